/* hw/rtl/slwe_pkg.sv */
// Shared constants, types and the n*log2(n) table for the local entropy block.
// No dependencies.
package slwe_pkg;

   localparam int MAX_WIDTH_DEF  = 128;
   localparam int MAX_HEIGHT_DEF = 128;
   localparam int MAX_RADIUS     = 7;
   localparam int VALUE_BITS     = 15;
   localparam int FRAC_BITS      = 16;

   localparam int WIN_MAX  = 2 * MAX_RADIUS + 1;
   localparam int ROM_SIZE = WIN_MAX * WIN_MAX + 1;
   localparam int CNT_W    = $clog2(ROM_SIZE);
   localparam int SUM_W    = 32;
   localparam int QUOT_W   = 17;
   localparam int ENT_W    = 17;
   localparam logic [ENT_W-1:0] ENT_ONE = ENT_W'(65536);

   localparam logic [7:0] REG_IMAGE_WIDTH  = 8'd0;
   localparam logic [7:0] REG_IMAGE_HEIGHT = 8'd1;
   localparam logic [7:0] REG_WINDOW_RADIUS = 8'd2;
   localparam logic [7:0] REG_COLOR_MODE   = 8'd3;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   localparam logic OP_REMOVE = 1'b0;
   localparam logic OP_ADD    = 1'b1;

   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_DOWN  = 2'd1;
   localparam logic [1:0] MODE_SIDE  = 2'd2;

   localparam logic [1:0] PHASE_IDLE = 2'd0;
   localparam logic [1:0] PHASE_RUN  = 2'd1;
   localparam logic [1:0] PHASE_DONE = 2'd2;

   typedef struct packed {
      logic       load;
      logic       scan_reset;
      logic       clr_step;
      logic       op_first;
      logic       op_next;
      logic       addr_load;
      logic       frame_rd;
      logic       hist_rd;
      logic       hist_upd;
      logic       commit;
      logic       div_start;
      logic       div_step;
      logic       out_load;
      logic [1:0] mode;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic op_last;
      logic div_last;
      logic step_down;
      logic last;
   } dp_status_type;

   typedef logic [ROM_SIZE-1:0][SUM_W-1:0] nlogn_table_type;

   // log2(n) with 32 fraction bits, by repeated squaring
   function automatic logic [63:0] log2_q32(input logic [31:0] n);
      logic [31:0] k;
      logic [63:0] m;
      logic [63:0] frac;
      k = '0;
      frac = '0;
      for (int i = 1; i < 32; i++) begin
         if ((n >> i) != 32'd0) k = 32'(i);
      end
      m = 64'(n) << (30 - k);
      for (int b = 31; b >= 0; b--) begin
         m = (m * m) >> 30;
         if (m >= 64'h8000_0000) begin
            m = m >> 1;
            frac[b] = 1'b1;
         end
      end
      return {k, frac[31:0]};
   endfunction

   function automatic nlogn_table_type build_nlogn_table();
      nlogn_table_type tbl;
      logic [63:0] v;
      tbl = '0;
      for (int n = 1; n < ROM_SIZE; n++) begin
         v = (64'(n) * log2_q32(32'(n)) + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
         tbl[n] = SUM_W'(v);
      end
      return tbl;
   endfunction

   localparam nlogn_table_type NLOGN_TABLE = build_nlogn_table();

   function automatic logic [SUM_W-1:0] nlogn(input logic [CNT_W-1:0] c);
      logic [SUM_W-1:0] v;
      v = '0;
      if (32'(c) < ROM_SIZE) v = NLOGN_TABLE[c];
      return v;
   endfunction

endpackage

/* hw/rtl/slwe_ifs.sv */
// Valid/ready channel interfaces: pixel/command input, entropy result, register write.
// No dependencies.
interface slwe_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] pixel_red;
   logic [7:0] pixel_green;
   logic [7:0] pixel_blue;
   modport source (output valid, cmd, pixel_red, pixel_green, pixel_blue, input ready);
   modport sink (input valid, cmd, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface slwe_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  col;
   logic [6:0]  row;
   logic [16:0] entropy_norm;
   logic        last;
   modport source (output valid, col, row, entropy_norm, last, input ready);
   modport sink (input valid, col, row, entropy_norm, last, output ready);
endinterface

interface slwe_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/slwe_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Depends on slwe_pkg for parameter defaults.
module slwe_ram #(
   parameter int WIDTH = slwe_pkg::VALUE_BITS,
   parameter int DEPTH = 1 << slwe_pkg::VALUE_BITS
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      if (re) rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* hw/rtl/slwe_ctrl.sv */
// Sequencer for the entropy block: handshakes, scan phase, per-pixel update steps.
// Depends on slwe_pkg; drives slwe_dp through ctrl_cmd_type.
module slwe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_cmd,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic                    csr_valid,
   input  logic [7:0]              csr_index,
   input  slwe_pkg::dp_status_type status,
   output slwe_pkg::ctrl_cmd_type  ctl
);
   import slwe_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_CLEAR  = 4'd1;
   localparam logic [3:0] ST_ADDR   = 4'd2;
   localparam logic [3:0] ST_FRD    = 4'd3;
   localparam logic [3:0] ST_HRD    = 4'd4;
   localparam logic [3:0] ST_UPD    = 4'd5;
   localparam logic [3:0] ST_COMMIT = 4'd6;
   localparam logic [3:0] ST_DIV    = 4'd7;
   localparam logic [3:0] ST_OUT    = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [1:0] mode_ff, mode_in;
   logic       valid_ff, valid_in;

   always_comb begin
      ctl = '0;
      state_in = state_ff;
      phase_in = phase_ff;
      mode_in = mode_ff;
      valid_in = valid_ff && !rsp_ready;
      req_ready = (state_ff == ST_IDLE);
      if (csr_valid && csr_index <= REG_COLOR_MODE && phase_ff == PHASE_RUN) begin
         phase_in = PHASE_IDLE;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_LOAD) begin
                  ctl.load = 1'b1;
                  if (phase_ff == PHASE_RUN) phase_in = PHASE_IDLE;
               end else if (phase_ff != PHASE_RUN) begin
                  mode_in = MODE_START;
                  ctl.scan_reset = 1'b1;
                  state_in = ST_CLEAR;
               end else begin
                  mode_in = status.step_down ? MODE_DOWN : MODE_SIDE;
                  ctl.op_first = 1'b1;
                  state_in = ST_ADDR;
               end
            end
         end
         ST_CLEAR: begin
            ctl.clr_step = 1'b1;
            if (status.clr_done) begin
               ctl.op_first = 1'b1;
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            ctl.addr_load = 1'b1;
            state_in = ST_FRD;
         end
         ST_FRD: begin
            ctl.frame_rd = 1'b1;
            state_in = ST_HRD;
         end
         ST_HRD: begin
            ctl.hist_rd = 1'b1;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            ctl.hist_upd = 1'b1;
            if (status.op_last) begin
               state_in = ST_COMMIT;
            end else begin
               ctl.op_next = 1'b1;
               state_in = ST_ADDR;
            end
         end
         ST_COMMIT: begin
            ctl.commit = 1'b1;
            ctl.div_start = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            ctl.div_step = 1'b1;
            if (status.div_last) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!valid_ff || rsp_ready) begin
               ctl.out_load = 1'b1;
               valid_in = 1'b1;
               phase_in = status.last ? PHASE_DONE : PHASE_RUN;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      ctl.mode = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PHASE_IDLE;
         mode_ff <= MODE_START;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         mode_ff <= mode_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
endmodule

/* hw/rtl/slwe_dp.sv */
// Datapath: registers, frame store, value histogram, n*log2(n) sum, divider, result.
// Depends on slwe_pkg and slwe_ram; commanded by slwe_ctrl.
module slwe_dp #(
   parameter int MAX_WIDTH  = slwe_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = slwe_pkg::MAX_HEIGHT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  slwe_pkg::ctrl_cmd_type  ctl,
   output slwe_pkg::dp_status_type status,
   input  logic [7:0]              pixel_red,
   input  logic [7:0]              pixel_green,
   input  logic [7:0]              pixel_blue,
   input  logic                    csr_valid,
   input  logic [7:0]              csr_index,
   input  logic [7:0]              csr_data,
   output logic [6:0]              col,
   output logic [6:0]              row,
   output logic [16:0]             entropy_norm,
   output logic                    last
);
   import slwe_pkg::*;

   localparam int CB    = $clog2(MAX_WIDTH);
   localparam int RB    = $clog2(MAX_HEIGHT);
   localparam int EW    = $clog2(MAX_WIDTH + 1);
   localparam int EH    = $clog2(MAX_HEIGHT + 1);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int PW    = $clog2(MAXD + 2 * MAX_RADIUS + 2) + 1;
   localparam int RADW  = $clog2(MAX_RADIUS + 1);
   localparam int IW    = $clog2(WIN_MAX);
   localparam int HD    = 1 << VALUE_BITS;
   localparam int NUMW  = SUM_W + QUOT_W + 1;
   localparam int REMW  = SUM_W + 2;
   localparam int DCW   = $clog2(QUOT_W);

   // configuration
   logic [7:0] width_ff, height_ff;
   logic [2:0] radius_ff;
   logic       cmode_ff;
   logic [EW-1:0]   eff_w;
   logic [EH-1:0]   eff_h;
   logic [RADW-1:0] eff_r;
   logic [IW-1:0]   span;
   logic [AW:0]     area;

   always_comb begin
      eff_w = (width_ff == 8'd0) ? EW'(1) :
              (32'(width_ff) > MAX_WIDTH) ? EW'(MAX_WIDTH) : EW'(width_ff);
      eff_h = (height_ff == 8'd0) ? EH'(1) :
              (32'(height_ff) > MAX_HEIGHT) ? EH'(MAX_HEIGHT) : EH'(height_ff);
      eff_r = (radius_ff == 3'd0) ? RADW'(1) :
              (32'(radius_ff) > MAX_RADIUS) ? RADW'(MAX_RADIUS) : RADW'(radius_ff);
      span = IW'({eff_r, 1'b0});
      area = (AW+1)'((AW+1)'(eff_w) * (AW+1)'(eff_h));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 8'd128;
         height_ff <= 8'd128;
         radius_ff <= 3'd4;
         cmode_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            REG_IMAGE_WIDTH:   width_ff <= csr_data;
            REG_IMAGE_HEIGHT:  height_ff <= csr_data;
            REG_WINDOW_RADIUS: radius_ff <= csr_data[2:0];
            REG_COLOR_MODE:    cmode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // pixel load
   logic [VALUE_BITS-1:0] pix_value;
   logic [AW-1:0]         ptr_ff, ptr_in, ptr_wr;
   logic [AW:0]           ptr_inc;

   always_comb begin
      pix_value = cmode_ff ?
                  VALUE_BITS'({pixel_red[7:3], pixel_green[7:3], pixel_blue[7:3]}) :
                  VALUE_BITS'(pixel_red);
      ptr_wr = ((AW+1)'(ptr_ff) >= area) ? '0 : ptr_ff;
      ptr_inc = (AW+1)'(ptr_wr) + (AW+1)'(1);
      ptr_in = ptr_ff;
      if (ctl.load) ptr_in = (ptr_inc >= area) ? '0 : AW'(ptr_inc);
   end

   // scan position and per-step counters
   logic [CB-1:0] scol_ff, scol_n;
   logic [RB-1:0] srow_ff, srow_n;
   logic          mright_ff, mright_n, step_ff, step_n, last_ff, last_n;
   logic [IW-1:0] a_ff, b_ff;
   logic          kind_ff;
   logic          op_last;

   logic signed [PW-1:0] r_s, a_s, b_s, col_s, row_s, h_s, w_s, pos_r, pos_c;
   logic                 inb;
   logic [AW-1:0]        addr;

   always_comb begin
      r_s = PW'(eff_r);
      a_s = PW'(a_ff);
      b_s = PW'(b_ff);
      col_s = PW'(scol_ff);
      row_s = PW'(srow_ff);
      h_s = PW'(eff_h);
      w_s = PW'(eff_w);
      case (ctl.mode)
         MODE_START: begin
            pos_r = a_s - r_s;
            pos_c = b_s - r_s;
         end
         MODE_DOWN: begin
            pos_c = col_s + a_s - r_s;
            pos_r = (kind_ff == OP_REMOVE) ? row_s - r_s : row_s + r_s + PW'(1);
         end
         default: begin
            pos_r = row_s + a_s - r_s;
            if (mright_ff) begin
               pos_c = (kind_ff == OP_REMOVE) ? col_s - r_s : col_s + r_s + PW'(1);
            end else begin
               pos_c = (kind_ff == OP_REMOVE) ? col_s + r_s : col_s - r_s - PW'(1);
            end
         end
      endcase
      inb = !pos_r[PW-1] && !pos_c[PW-1] && (pos_r < h_s) && (pos_c < w_s);
      addr = AW'(AW'(pos_r[RB-1:0]) * AW'(eff_w) + AW'(pos_c[CB-1:0]));
      if (ctl.mode == MODE_START) begin
         op_last = (a_ff == span) && (b_ff == span);
      end else begin
         op_last = (a_ff == span) && (kind_ff == OP_ADD);
      end
   end

   always_comb begin
      scol_n = scol_ff;
      srow_n = srow_ff;
      mright_n = mright_ff;
      case (ctl.mode)
         MODE_DOWN: begin
            mright_n = !mright_ff;
            srow_n = srow_ff + RB'(1);
         end
         MODE_SIDE: begin
            scol_n = mright_ff ? scol_ff + CB'(1) : scol_ff - CB'(1);
         end
         default: ;
      endcase
      step_n = mright_n ? ((EW+1)'(scol_n) + (EW+1)'(1) >= (EW+1)'(eff_w)) : (scol_n == '0);
      last_n = step_n && ((EH+1)'(srow_n) + (EH+1)'(1) >= (EH+1)'(eff_h));
   end

   // frame store and histogram
   logic [AW-1:0]         addr_ff;
   logic                  inb_ff;
   logic [VALUE_BITS-1:0] fdata, hvalue, val_ff, clr_ff;
   logic [CNT_W-1:0]      hdata, newc;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic                  hist_we;
   logic [VALUE_BITS-1:0] hist_waddr;
   logic [CNT_W-1:0]      hist_wdata;

   slwe_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_frame (
      .clock(clock), .we(ctl.load), .waddr(ptr_wr), .wdata(pix_value),
      .re(ctl.frame_rd), .raddr(addr_ff), .rdata(fdata)
   );

   assign hvalue = inb_ff ? fdata : '0;

   always_comb begin
      newc = hdata;
      if (kind_ff == OP_ADD) begin
         if (32'(hdata) + 1 < ROM_SIZE) newc = hdata + CNT_W'(1);
      end else if (hdata != '0) begin
         newc = hdata - CNT_W'(1);
      end
      sum_in = sum_ff - nlogn(hdata) + nlogn(newc);
      hist_we = ctl.clr_step || ctl.hist_upd;
      hist_waddr = ctl.clr_step ? clr_ff : val_ff;
      hist_wdata = ctl.clr_step ? '0 : newc;
   end

   slwe_ram #(.WIDTH(CNT_W), .DEPTH(HD)) u_hist (
      .clock(clock), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
      .re(ctl.hist_rd), .raddr(hvalue), .rdata(hdata)
   );

   // restoring divider: q = (S*2^17 + D) / (2D)
   logic [SUM_W-1:0]  dval;
   logic [NUMW-1:0]   num;
   logic [REMW-1:0]   rem_ff, den_ff, rem_t;
   logic [QUOT_W-1:0] low_ff, q_ff;
   logic [DCW-1:0]    dcnt_ff;
   logic [IW:0]       win;

   always_comb begin
      win = (IW+1)'(span) + (IW+1)'(1);
      dval = nlogn(CNT_W'(win) * CNT_W'(win));
      num = NUMW'({sum_ff, QUOT_W'(0)}) + NUMW'(dval);
      rem_t = {rem_ff[REMW-2:0], low_ff[QUOT_W-1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         scol_ff <= '0;
         srow_ff <= '0;
         mright_ff <= 1'b1;
         step_ff <= 1'b0;
         last_ff <= 1'b0;
         sum_ff <= '0;
         clr_ff <= '0;
         a_ff <= '0;
         b_ff <= '0;
         kind_ff <= OP_ADD;
         dcnt_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
         if (ctl.scan_reset) begin
            scol_ff <= '0;
            srow_ff <= '0;
            mright_ff <= 1'b1;
            sum_ff <= '0;
            clr_ff <= '0;
         end
         if (ctl.clr_step) clr_ff <= clr_ff + VALUE_BITS'(1);
         if (ctl.hist_upd) sum_ff <= sum_in;
         if (ctl.commit) begin
            scol_ff <= scol_n;
            srow_ff <= srow_n;
            mright_ff <= mright_n;
            step_ff <= step_n;
            last_ff <= last_n;
         end
         if (ctl.op_first) begin
            a_ff <= '0;
            b_ff <= '0;
            kind_ff <= (ctl.mode == MODE_START) ? OP_ADD : OP_REMOVE;
         end else if (ctl.op_next) begin
            if (ctl.mode == MODE_START) begin
               if (b_ff == span) begin
                  b_ff <= '0;
                  a_ff <= a_ff + IW'(1);
               end else begin
                  b_ff <= b_ff + IW'(1);
               end
            end else if (kind_ff == OP_ADD) begin
               kind_ff <= OP_REMOVE;
               a_ff <= a_ff + IW'(1);
            end else begin
               kind_ff <= OP_ADD;
            end
         end
         if (ctl.div_start) dcnt_ff <= '0;
         else if (ctl.div_step) dcnt_ff <= dcnt_ff + DCW'(1);
      end
   end

   logic [6:0]       col_ff, row_ff;
   logic [ENT_W-1:0] ent_ff;
   logic             rlast_ff;

   always_ff @(posedge clock) begin
      if (ctl.addr_load) begin
         addr_ff <= addr;
         inb_ff <= inb;
      end
      if (ctl.hist_rd) val_ff <= hvalue;
      if (ctl.div_start) begin
         rem_ff <= REMW'(num >> QUOT_W);
         low_ff <= num[QUOT_W-1:0];
         den_ff <= REMW'({dval, 1'b0});
         q_ff <= '0;
      end else if (ctl.div_step) begin
         low_ff <= {low_ff[QUOT_W-2:0], 1'b0};
         if (rem_t >= den_ff) begin
            rem_ff <= rem_t - den_ff;
            q_ff <= {q_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_t;
            q_ff <= {q_ff[QUOT_W-2:0], 1'b0};
         end
      end
      if (ctl.out_load) begin
         col_ff <= 7'(scol_ff);
         row_ff <= 7'(srow_ff);
         ent_ff <= (ENT_W'(q_ff) > ENT_ONE) ? '0 : ENT_ONE - ENT_W'(q_ff);
         rlast_ff <= last_ff;
      end
   end

   always_comb begin
      status.clr_done = (clr_ff == VALUE_BITS'(HD - 1));
      status.op_last = op_last;
      status.div_last = (dcnt_ff == DCW'(QUOT_W - 1));
      status.step_down = step_ff;
      status.last = last_ff;
   end

   assign col = col_ff;
   assign row = row_ff;
   assign entropy_norm = ent_ff;
   assign last = rlast_ff;
endmodule

/* hw/rtl/sliding_window_local_entropy.sv */
// Local entropy over a sliding (2r+1)x(2r+1) window, serpentine scan of a stored frame.
// Load item (cmd 0): written to the frame store, no result. Advance item (cmd 1): each
// histogram update is address, frame read, histogram read, write back; 2w updates per move, w*w
// at scan start plus a clearing pass over all 32768 histogram entries; then a commit, the
// 17-bit restoring division and an output step. Default w = 9. One item in flight at a time.
// Synchronous active-high reset clears control and scan/counter registers; memories are not cleared.
module sliding_window_local_entropy #(
   parameter int MAX_WIDTH  = slwe_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = slwe_pkg::MAX_HEIGHT_DEF
) (
   input logic         clock,
   input logic         reset,
   slwe_req_if.sink    req,
   slwe_rsp_if.source  rsp,
   slwe_csr_if.sink    csr
);
   import slwe_pkg::*;

   ctrl_cmd_type  ctl;
   dp_status_type status;

   assign csr.ready = 1'b1;

   slwe_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_cmd(req.cmd),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .csr_valid(csr.valid), .csr_index(csr.index),
      .status(status), .ctl(ctl)
   );

   slwe_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .status(status),
      .pixel_red(req.pixel_red), .pixel_green(req.pixel_green),
      .pixel_blue(req.pixel_blue),
      .csr_valid(csr.valid), .csr_index(csr.index), .csr_data(csr.data),
      .col(rsp.col), .row(rsp.row), .entropy_norm(rsp.entropy_norm), .last(rsp.last)
   );
endmodule

/* hw/rtl/slwe_chk.sv */
// Port-level checks for sliding_window_local_entropy, attached by bind.
// Depends on the top level's interface ports only.
module slwe_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_cmd,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [16:0] rsp_entropy_norm
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entropy_norm))
      else $error("result dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entropy_norm <= 17'd65536)
      else $error("entropy above one");

   a_no_fast_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd |=> !$rose(rsp_valid))
      else $error("result too soon after advance item");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_cmd && !rsp_valid |=> !rsp_valid)
      else $error("load item produced a result");
endmodule

bind sliding_window_local_entropy slwe_chk u_slwe_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready), .req_cmd(req.cmd),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_entropy_norm(rsp.entropy_norm)
);
